### rtl/fifo_fair_reader_writer_lock_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the lock manager RTL (rwl_ctrl)
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FIFO_FAIR_READER_WRITER_LOCK_MACROS_SVH
`define FIFO_FAIR_READER_WRITER_LOCK_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define RWL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define RWL_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/rwl_pkg.sv
// ----------------------------------------------------------------------------
// rwl_pkg
// Types and codes of the fair readers/writers lock manager.
// ----------------------------------------------------------------------------
package rwl_pkg;

  localparam int unsigned WhoW   = 6;
  localparam int unsigned TypeW  = 2;
  localparam int unsigned EventW = 3;

  typedef enum logic [TypeW-1:0] {
    REQ_READ_LOCK    = 2'd0,
    REQ_WRITE_LOCK   = 2'd1,
    REQ_READ_UNLOCK  = 2'd2,
    REQ_WRITE_UNLOCK = 2'd3
  } rwl_req_e;

  typedef enum logic [EventW-1:0] {
    EV_GRANT    = 3'd0,
    EV_QUEUED   = 3'd1,
    EV_NOGRANT  = 3'd2,
    EV_FULL     = 3'd3,
    EV_NOHOLDER = 3'd4
  } rwl_event_e;

  // One waiting request as stored in the queue memory.
  typedef struct packed {
    logic            wr;
    logic [WhoW-1:0] who;
  } rwl_entry_t;

  typedef struct packed {
    rwl_req_e        req_type;
    logic [WhoW-1:0] requester;
  } rwl_cmd_t;

  typedef struct packed {
    rwl_event_e      event_res;
    logic [WhoW-1:0] who;
    logic            grant_write;
    logic            last;
  } rwl_res_t;

endpackage

### rtl/rwl_if.sv
// ----------------------------------------------------------------------------
// rwl_if
// Valid/ready channels for lock requests and lock events.
// ----------------------------------------------------------------------------
interface rwl_req_if;
  logic                        valid;
  logic                        ready;
  logic [rwl_pkg::TypeW-1:0]   req_type;
  logic [rwl_pkg::WhoW-1:0]    requester;

  modport source (output valid, output req_type, output requester, input ready);
  modport sink   (input valid, input req_type, input requester, output ready);
endinterface

interface rwl_res_if;
  logic                        valid;
  logic                        ready;
  logic [rwl_pkg::EventW-1:0]  event_res;
  logic [rwl_pkg::WhoW-1:0]    who;
  logic                        grant_write;
  logic                        last;

  modport source (output valid, output event_res, output who, output grant_write,
                  output last, input ready);
  modport sink   (input valid, input event_res, input who, input grant_write,
                  input last, output ready);
endinterface

### rtl/fifo_fair_reader_writer_lock.sv
// ----------------------------------------------------------------------------
// fifo_fair_reader_writer_lock
// Fair FIFO readers/writers lock manager with a memory-based wait queue.
// ----------------------------------------------------------------------------
// A single-result request loads its event beat into the output register in
// ST_EXEC once the output is free. A release with waiters reads the head entry
// in ST_EXEC and pops it in ST_FIRST, then one grant per cycle over the reads
// while the output is not stalled. New requests are taken only in ST_IDLE.
// Reset: holder counts and queue pointers clear; the queue memory is not
// cleared, and no clearing pass runs.
module fifo_fair_reader_writer_lock #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rwl_req_if.sink    req_i,
  rwl_res_if.source  res_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  logic                mem_wr_en;
  logic [PtrW-1:0]     mem_wr_addr;
  rwl_pkg::rwl_entry_t mem_wr_data;
  logic                mem_rd_en;
  logic [PtrW-1:0]     mem_rd_addr;
  rwl_pkg::rwl_entry_t mem_rd_data;

  rwl_ctrl #(
    .QueueDepth (QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .res_o         (res_o),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data)
  );

  rwl_queue_mem #(
    .Depth (QUEUE_DEPTH)
  ) u_queue_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

endmodule

### rtl/rwl_queue_mem.sv
// ----------------------------------------------------------------------------
// rwl_queue_mem
// Wait queue storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rwl_queue_mem #(
  parameter int unsigned  Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  rwl_pkg::rwl_entry_t wr_data_i,
  input  logic                rd_en_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  output rwl_pkg::rwl_entry_t rd_data_o
);

  rwl_pkg::rwl_entry_t mem_q [Depth];
  rwl_pkg::rwl_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    // read data holds until the next read
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/rwl_ctrl.sv
// ----------------------------------------------------------------------------
// rwl_ctrl
// Request sequencer: holder counts, queue pointers, release walk, event beat.
// ----------------------------------------------------------------------------
`include "fifo_fair_reader_writer_lock_macros.svh"

module rwl_ctrl #(
  parameter int unsigned  QueueDepth = 16,
  localparam int unsigned PtrW = $clog2(QueueDepth),
  localparam int unsigned CntW = $clog2(QueueDepth + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  rwl_req_if.sink             req_i,
  rwl_res_if.source           res_o,
  output logic                mem_wr_en_o,
  output logic [PtrW-1:0]     mem_wr_addr_o,
  output rwl_pkg::rwl_entry_t mem_wr_data_o,
  output logic                mem_rd_en_o,
  output logic [PtrW-1:0]     mem_rd_addr_o,
  input  rwl_pkg::rwl_entry_t mem_rd_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_FIRST = 5'b00100,
    ST_NEXT  = 5'b01000,
    ST_OUT   = 5'b10000
  } rwl_state_e;

  rwl_state_e          state_q, state_d;
  rwl_pkg::rwl_cmd_t   cmd_q, cmd_d;
  rwl_pkg::rwl_entry_t cur_q, cur_d;
  rwl_pkg::rwl_res_t   out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic [PtrW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     readers_q, readers_d;
  logic                writer_q, writer_d;

  logic                out_free;
  logic                out_load;
  logic                holders_free;
  logic                queue_full;
  logic                lock_wr;
  logic [PtrW-1:0]     head_inc;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign out_free     = !out_valid_q || res_o.ready;
  assign holders_free = (readers_q == '0) && !writer_q;
  assign queue_full   = (count_q == CntW'(QueueDepth));
  assign lock_wr      = (cmd_q.req_type == rwl_pkg::REQ_WRITE_LOCK);
  assign head_inc     = ptr_inc(head_q);

  assign req_i.ready  = (state_q == ST_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    cur_d         = cur_q;
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    readers_d     = readers_q;
    writer_d      = writer_q;
    out_load      = 1'b0;
    out_d         = out_q;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = tail_q;
    mem_wr_data_o = '{wr: lock_wr, who: cmd_q.requester};
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = head_q;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          cmd_d   = '{req_type:  rwl_pkg::rwl_req_e'(req_i.req_type),
                      requester: req_i.requester};
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (cmd_q.req_type)
          rwl_pkg::REQ_READ_LOCK, rwl_pkg::REQ_WRITE_LOCK: begin
            if (out_free) begin
              out_load = 1'b1;
              state_d  = ST_IDLE;
              if (holders_free) begin
                out_d = '{rwl_pkg::EV_GRANT, cmd_q.requester, lock_wr, 1'b1};
                if (lock_wr) begin
                  writer_d = 1'b1;
                end else begin
                  readers_d = CntW'(1);
                end
              end else if (queue_full) begin
                out_d = '{rwl_pkg::EV_FULL, cmd_q.requester, lock_wr, 1'b1};
              end else begin
                out_d       = '{rwl_pkg::EV_QUEUED, cmd_q.requester, lock_wr, 1'b1};
                mem_wr_en_o = 1'b1;
                tail_d      = ptr_inc(tail_q);
                count_d     = count_q + 1'b1;
              end
            end
          end

          rwl_pkg::REQ_READ_UNLOCK, rwl_pkg::REQ_WRITE_UNLOCK: begin
            if ((cmd_q.req_type == rwl_pkg::REQ_READ_UNLOCK) ? (readers_q == '0)
                                                            : !writer_q) begin
              if (out_free) begin
                out_load = 1'b1;
                out_d    = '{rwl_pkg::EV_NOHOLDER, cmd_q.requester, 1'b0, 1'b1};
                state_d  = ST_IDLE;
              end
            end else if (cmd_q.req_type == rwl_pkg::REQ_READ_UNLOCK &&
                         (readers_q != CntW'(1) || writer_q)) begin
              // other holders remain
              if (out_free) begin
                out_load  = 1'b1;
                out_d     = '{rwl_pkg::EV_NOGRANT, cmd_q.requester, 1'b0, 1'b1};
                readers_d = readers_q - 1'b1;
                state_d   = ST_IDLE;
              end
            end else if (count_q == '0) begin
              if (out_free) begin
                out_load  = 1'b1;
                out_d     = '{rwl_pkg::EV_NOGRANT, cmd_q.requester, 1'b0, 1'b1};
                readers_d = '0;
                writer_d  = 1'b0;
                state_d   = ST_IDLE;
              end
            end else begin
              // release with waiters: fetch the head entry
              readers_d   = '0;
              writer_d    = 1'b0;
              mem_rd_en_o = 1'b1;
              state_d     = ST_FIRST;
            end
          end

          default: state_d = ST_IDLE;
        endcase
      end

      ST_FIRST: begin
        // head entry is granted unconditionally
        cur_d   = mem_rd_data_i;
        head_d  = head_inc;
        count_d = count_q - 1'b1;
        if (mem_rd_data_i.wr) begin
          writer_d = 1'b1;
        end else begin
          readers_d = readers_q + 1'b1;
        end
        if (mem_rd_data_i.wr || count_q == CntW'(1)) begin
          state_d = ST_OUT;
        end else begin
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = head_inc;
          state_d       = ST_NEXT;
        end
      end

      ST_NEXT: begin
        // cur_q is a granted read; read data shows the entry behind it
        if (out_free) begin
          out_load = 1'b1;
          if (!mem_rd_data_i.wr) begin
            out_d     = '{rwl_pkg::EV_GRANT, cur_q.who, 1'b0, 1'b0};
            cur_d     = mem_rd_data_i;
            head_d    = head_inc;
            count_d   = count_q - 1'b1;
            readers_d = readers_q + 1'b1;
            if (count_q == CntW'(1)) begin
              state_d = ST_OUT;
            end else begin
              mem_rd_en_o   = 1'b1;
              mem_rd_addr_o = head_inc;
            end
          end else begin
            out_d   = '{rwl_pkg::EV_GRANT, cur_q.who, 1'b0, 1'b1};
            state_d = ST_IDLE;
          end
        end
      end

      ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = '{rwl_pkg::EV_GRANT, cur_q.who, cur_q.wr, 1'b1};
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      readers_q   <= '0;
      writer_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      readers_q   <= readers_d;
      writer_q    <= writer_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    cur_q <= cur_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.event_res   = out_q.event_res;
  assign res_o.who         = out_q.who;
  assign res_o.grant_write = out_q.grant_write;
  assign res_o.last        = out_q.last;

  `RWL_ASSERT_NEVER(a_rw_exclusive, writer_q && (readers_q != '0), "writer and readers both hold")
  `RWL_ASSERT_NEVER(a_count_bound, count_q > CntW'(QueueDepth), "queue count above depth")
  `RWL_ASSERT_NEVER(a_mem_port_clash, mem_wr_en_o && mem_rd_en_o, "queue read and write together")
  `RWL_ASSERT(a_done_on_last, (state_q != ST_IDLE && state_d == ST_IDLE) |-> (out_load && out_d.last), "item ended without a last beat")
  `RWL_ASSERT(a_walk_needs_waiter, (state_q == ST_NEXT) |-> (count_q != '0), "release walk on empty queue")

endmodule
